### sv/thp_pkg.sv
// shared types and constants of the tile pixel hash
// seeds, finalizer constants, beat field positions and the 32x32 multiply helper
// no dependencies
package thp_pkg;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned CNT_W     = 3;

    localparam int unsigned IN_DATA_W  = 296;
    localparam int unsigned OUT_DATA_W = 128;

    localparam int unsigned VL_LSB    = NUM_LANES * WORD_W;
    localparam int unsigned TP_BIT    = VL_LSB + CNT_W;
    localparam int unsigned TV_LSB    = TP_BIT + 1;
    localparam int unsigned PAD_LSB   = TV_LSB + HALF_W;

    localparam logic [NUM_LANES-1:0][WORD_W-1:0] SEEDS = {
        64'hbf58476d1ce4e5b9,
        64'h9e3779b97f4a7c15,
        64'h6c62272e07bb0142,
        64'h517cc1b727220a95
    };

    localparam logic [WORD_W-1:0] MUL_LOW  = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] MUL_HIGH = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned SHIFT_LOW  = 33;
    localparam int unsigned SHIFT_HIGH = 29;

    typedef struct packed {
        logic [WORD_W-1:0] high;
        logic [WORD_W-1:0] low;
    } t_pair;

    function automatic logic [WORD_W-1:0] mul32(input logic [HALF_W-1:0] a,
                                                input logic [HALF_W-1:0] b);
        return {{HALF_W{1'b0}}, a} * {{HALF_W{1'b0}}, b};
    endfunction

endpackage

### sv/thp_lane.sv
// one accumulator lane: adds the lane word when enabled plus an extra addend
// uses thp_pkg
module thp_lane
    import thp_pkg::*;
(
    input  logic [WORD_W-1:0] i_acc,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_en,
    input  logic [WORD_W-1:0] i_extra,
    output logic [WORD_W-1:0] o_sum
);

    logic [WORD_W-1:0] word_m;

    assign word_m = i_en ? i_word : '0;
    assign o_sum  = i_acc + word_m + i_extra;

endmodule

### sv/thp_final.sv
// three-stage finalizer: xorshift, split 32-bit partial products, recombine and xorshift
// uses thp_pkg; each stage advances when the next one is empty or moving
module thp_final
    import thp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_pair i_fold,
    output logic  o_valid,
    input  logic  i_ready,
    output t_pair o_hash
);

    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    t_pair r_s1;
    logic [WORD_W-1:0] r_pll_f, r_pll_g;
    logic [HALF_W-1:0] r_phl_f, r_plh_f, r_phl_g, r_plh_g;
    t_pair r_s3;

    logic [WORD_W-1:0] x_f, x_g;
    logic [WORD_W-1:0] pll_f, phl_f, plh_f, pll_g, phl_g, plh_g;
    logic [HALF_W-1:0] cross_f, cross_g;
    logic [WORD_W-1:0] m_f, m_g;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // stage two: xorshift then partial products of the low 64 bits
    assign x_f   = r_s1.low  ^ (r_s1.low  >> SHIFT_LOW);
    assign x_g   = r_s1.high ^ (r_s1.high >> SHIFT_HIGH);
    assign pll_f = mul32(x_f[HALF_W-1:0], MUL_LOW[HALF_W-1:0]);
    assign phl_f = mul32(x_f[WORD_W-1:HALF_W], MUL_LOW[HALF_W-1:0]);
    assign plh_f = mul32(x_f[HALF_W-1:0], MUL_LOW[WORD_W-1:HALF_W]);
    assign pll_g = mul32(x_g[HALF_W-1:0], MUL_HIGH[HALF_W-1:0]);
    assign phl_g = mul32(x_g[WORD_W-1:HALF_W], MUL_HIGH[HALF_W-1:0]);
    assign plh_g = mul32(x_g[HALF_W-1:0], MUL_HIGH[WORD_W-1:HALF_W]);

    // stage three: recombine, then xorshift
    assign cross_f = r_phl_f + r_plh_f;
    assign cross_g = r_phl_g + r_plh_g;
    assign m_f     = r_pll_f + {cross_f, {HALF_W{1'b0}}};
    assign m_g     = r_pll_g + {cross_g, {HALF_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= i_fold;
        end
        if (adv2) begin
            r_pll_f <= pll_f;
            r_phl_f <= phl_f[HALF_W-1:0];
            r_plh_f <= plh_f[HALF_W-1:0];
            r_pll_g <= pll_g;
            r_phl_g <= phl_g[HALF_W-1:0];
            r_plh_g <= plh_g[HALF_W-1:0];
        end
        if (adv3) begin
            r_s3.low  <= m_f ^ (m_f >> SHIFT_LOW);
            r_s3.high <= m_g ^ (m_g >> SHIFT_HIGH);
        end
    end

    assign o_valid = r_v3;
    assign o_hash  = r_s3;

`ifndef NO_ASSERTIONS
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3 && !i_ready))
        else $error("finalizer blocked while a stage is empty");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted beat missing from stage one");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2) |=> r_v2)
        else $error("stage one beat lost on advance");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !adv3) |=> (r_v2 && $stable(r_pll_f) && $stable(r_pll_g)))
        else $error("stage two changed during stall");
`endif

endmodule

### sv/tile_pixel_hash_128.sv
// tile pixel hash top level: four accumulator lanes, row mix and fold, finalizer pipeline
// uses thp_pkg, thp_lane, thp_final
//
// One chunk beat is taken every cycle while tready is high; the four lane adds,
// the tail add and the row mix of a beat complete in the same cycle, and that
// accumulate loop sets the one-beat-per-cycle rate. A beat with tile end set
// produces one 128-bit hash on the master side through a three-stage
// finalizer that builds each 64x64 product from 32x32 partial products.
// The finalizer holds up to three hashes, so chunks keep flowing while a hash
// waits; tready drops only when all three stages are full and stalled.
module tile_pixel_hash_128
    import thp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // lane_word_0, lane_word_1, lane_word_2, lane_word_3, valid_lanes,
    // tail_present, tail_value, zero fill
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // tile_end
    input  logic                  i_s_tlast,
    // row_end
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // hash_low, hash_high
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic [NUM_LANES-1:0][WORD_W-1:0] r_acc;
    logic [NUM_LANES-1:0][WORD_W-1:0] n_acc;
    logic [NUM_LANES-1:0][WORD_W-1:0] sum;
    logic [NUM_LANES-1:0][WORD_W-1:0] mixed;
    logic [CNT_W-1:0]  valid_lanes;
    logic [WORD_W-1:0] tail_ext;
    logic              accept;
    logic              fin_ready;
    t_pair             fold;
    t_pair             hash;

    assign valid_lanes = i_s_tdata[VL_LSB +: CNT_W];
    assign tail_ext    = i_s_tdata[TP_BIT] ?
                         {{(WORD_W-HALF_W){1'b0}}, i_s_tdata[TV_LSB +: HALF_W]} : '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_LANES; gi++) begin : g_lane
            thp_lane u_lane (
                .i_acc   (r_acc[gi]),
                .i_word  (i_s_tdata[gi*WORD_W +: WORD_W]),
                .i_en    (valid_lanes > CNT_W'(gi)),
                .i_extra ((gi == NUM_LANES - 1) ? tail_ext : {WORD_W{1'b0}}),
                .o_sum   (sum[gi])
            );
        end
    endgenerate

    // row mix
    always_comb begin
        mixed = sum;
        if (i_s_tuser) begin
            mixed[0] = sum[0] ^ sum[2];
            mixed[1] = sum[1] ^ sum[3];
            mixed[2] = sum[2] + mixed[0];
            mixed[3] = sum[3] + mixed[1];
        end
    end

    assign fold.low  = mixed[0] ^ mixed[2];
    assign fold.high = mixed[1] ^ mixed[3];

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = fin_ready;
    assign n_acc      = i_s_tlast ? SEEDS : mixed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= SEEDS;
        end else if (accept) begin
            r_acc <= n_acc;
        end
    end

    thp_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid && i_s_tlast),
        .o_ready (fin_ready),
        .i_fold  (fold),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_hash  (hash)
    );

    assign o_m_tdata = {hash.high, hash.low};

endmodule

### verif/tb_top.sv
// testbench for tile_pixel_hash_128: chunk beats in, 128-bit tile hashes out
// keeps its own accumulator copy to predict each hash, checks every output beat
// depends on thp_pkg and the tile_pixel_hash_128 top level
module tb_top
    import thp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SEED_0 = 64'h517cc1b727220a95;
    localparam logic [63:0] SEED_1 = 64'h6c62272e07bb0142;
    localparam logic [63:0] SEED_2 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SEED_3 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] FMIX_LO_MUL = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_HI_MUL = 64'hc4ceb9fe1a85ec53;
    localparam int FMIX_LO_SHIFT = 33;
    localparam int FMIX_HI_SHIFT = 29;

    typedef struct packed {
        logic [3:0][63:0] lane;
        logic [2:0]       vlanes;
        logic             tail_on;
        logic [31:0]      tail;
        logic             row_end;
        logic             tile_end;
    } t_chunk;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_digest;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [63:0] acc [4];
    t_digest     digest_q [$];
    t_digest     want;
    int          errors;
    int          chunks_sent;
    bit          gaps_on;
    bit          stalls_on;
    int          hold_left;
    int          stall_left;

    tile_pixel_hash_128 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reseed_accs();
        acc[0] = SEED_0;
        acc[1] = SEED_1;
        acc[2] = SEED_2;
        acc[3] = SEED_3;
    endfunction

    function automatic void absorb_chunk(t_chunk c);
        int n;
        logic [63:0] f;
        logic [63:0] g;
        t_digest d;
        n = (c.vlanes > 3'd4) ? 4 : int'(c.vlanes);
        for (int i = 0; i < 4; i++) begin
            if (i < n) acc[i] = acc[i] + c.lane[i];
        end
        if (c.tail_on) acc[3] = acc[3] + {32'd0, c.tail};
        if (c.row_end) begin
            acc[0] = acc[0] ^ acc[2];
            acc[1] = acc[1] ^ acc[3];
            acc[2] = acc[2] + acc[0];
            acc[3] = acc[3] + acc[1];
        end
        if (c.tile_end) begin
            f = acc[0] ^ acc[2];
            g = acc[1] ^ acc[3];
            f = f ^ (f >> FMIX_LO_SHIFT);
            f = f * FMIX_LO_MUL;
            f = f ^ (f >> FMIX_LO_SHIFT);
            g = g ^ (g >> FMIX_HI_SHIFT);
            g = g * FMIX_HI_MUL;
            g = g ^ (g >> FMIX_HI_SHIFT);
            d.lo = f;
            d.hi = g;
            digest_q.push_back(d);
            reseed_accs();
        end
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_chunk make_chunk(logic [3:0][63:0] lane, logic [2:0] vlanes,
                                          logic tail_on, logic [31:0] tail,
                                          logic row_end, logic tile_end);
        t_chunk c;
        c.lane = lane;
        c.vlanes = vlanes;
        c.tail_on = tail_on;
        c.tail = tail;
        c.row_end = row_end;
        c.tile_end = tile_end;
        return c;
    endfunction

    function automatic t_chunk rand_chunk(logic row_end, logic tile_end);
        t_chunk c;
        int pick;
        for (int i = 0; i < 4; i++) c.lane[i] = rand_word();
        pick = $urandom_range(0, 11);
        c.vlanes = (pick > 7) ? 3'd4 : pick[2:0];
        c.tail_on = 1'($urandom_range(0, 1));
        c.tail = ($urandom_range(0, 5) == 0) ? '1 : $urandom;
        c.row_end = row_end;
        c.tile_end = tile_end;
        return c;
    endfunction

    // called just after a rising edge (or at start); returns at the accepting edge
    task automatic send_chunk(t_chunk c);
        int idle;
        idle = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
        if (idle > 0) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, c.tail, c.tail_on, c.vlanes, c.lane};
        s_tlast  = c.tile_end;
        s_tuser  = c.row_end;
        do @(posedge i_clk); while (!s_tready);
        absorb_chunk(c);
        chunks_sent++;
    endtask

    task automatic send_tile(int rows, int row_len, bit noise);
        t_chunk c;
        for (int r = 0; r < rows; r++) begin
            for (int k = 0; k < row_len; k++) begin
                c = rand_chunk(k == row_len - 1, (r == rows - 1) && (k == row_len - 1));
                if (noise && $urandom_range(0, 7) == 0) begin
                    c.row_end = 1'($urandom_range(0, 1));
                    c.tile_end = 1'($urandom_range(0, 1));
                end
                send_chunk(c);
            end
        end
    endtask

    task automatic test_empty_tile();
        send_chunk(make_chunk('0, 3'd0, 1'b0, 32'd0, 1'b0, 1'b1));
        send_chunk(make_chunk('1, 3'd0, 1'b0, '1, 1'b0, 1'b1));
        send_chunk(rand_chunk(1'b0, 1'b0));
        send_chunk(make_chunk('0, 3'd0, 1'b0, 32'd0, 1'b0, 1'b1));
    endtask

    task automatic test_lane_extremes();
        send_chunk(make_chunk('1, 3'd4, 1'b0, 32'd0, 1'b0, 1'b0));
        send_chunk(make_chunk('1, 3'd4, 1'b0, 32'd0, 1'b1, 1'b1));
        send_chunk(make_chunk('0, 3'd4, 1'b0, 32'd0, 1'b1, 1'b1));
    endtask

    task automatic test_lane_counts();
        for (int n = 1; n < 8; n++) begin
            send_chunk(make_chunk({rand_word(), rand_word(), rand_word(), rand_word()},
                                  n[2:0], 1'b0, 32'd0, 1'b0, 1'b0));
        end
        send_chunk(make_chunk('1, 3'd7, 1'b0, 32'd0, 1'b1, 1'b1));
    endtask

    task automatic test_tail();
        send_chunk(make_chunk('1, 3'd4, 1'b1, '1, 1'b0, 1'b0));
        send_chunk(make_chunk('0, 3'd0, 1'b1, 32'd0, 1'b0, 1'b0));
        send_chunk(make_chunk('1, 3'd2, 1'b1, 32'h8000_0001, 1'b1, 1'b1));
    endtask

    task automatic test_row_mix();
        send_chunk(rand_chunk(1'b1, 1'b0));
        send_chunk(rand_chunk(1'b1, 1'b0));
        send_chunk(rand_chunk(1'b0, 1'b0));
        send_chunk(rand_chunk(1'b0, 1'b1));
    endtask

    // receiver holds off while tile ends keep arriving, so the finalizer fills up
    task automatic test_backpressure();
        hold_left = 300;
        for (int i = 0; i < 40; i++) send_chunk(rand_chunk(1'($urandom_range(0, 1)), 1'b1));
    endtask

    task automatic test_random_tiles(int target);
        while (chunks_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                send_chunk(rand_chunk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end else begin
                send_tile($urandom_range(1, 3), $urandom_range(1, 4), 1'b1);
            end
        end
    endtask

    task automatic test_full_rate(int target);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        while (chunks_sent < target) send_tile($urandom_range(1, 3), $urandom_range(1, 3), 1'b0);
    endtask

    initial begin
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                errors++;
                $display("%0t: hash beat expected none got %h", $realtime, m_tdata);
            end else begin
                want = digest_q.pop_front();
                if (m_tdata[63:0] !== want.lo) begin
                    errors++;
                    $display("%0t: hash_low expected %h got %h",
                             $realtime, want.lo, m_tdata[63:0]);
                end
                if (m_tdata[127:64] !== want.hi) begin
                    errors++;
                    $display("%0t: hash_high expected %h got %h",
                             $realtime, want.hi, m_tdata[127:64]);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_tuser = 1'b0;
        errors = 0;
        chunks_sent = 0;
        hold_left = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        reseed_accs();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_empty_tile();
        test_lane_extremes();
        test_lane_counts();
        test_tail();
        test_row_mix();
        test_backpressure();
        test_random_tiles(1250);
        test_full_rate(1420);

        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
